// ===== rtl/lease_slot_arbiter_with_wait_queues_core_defines.svh =====
// Assertion macros used by the checker file.
// Depends on nothing; expects clk and rst_n in the scope of use.
`ifndef LEASE_SLOT_ARBITER_WITH_WAIT_QUEUES_CORE_DEFINES_SVH
`define LEASE_SLOT_ARBITER_WITH_WAIT_QUEUES_CORE_DEFINES_SVH

// same-cycle implication
`define LSA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/lsa_pkg.sv =====
// Shared types and codes for the lease slot arbiter.
// No dependencies.
package lsa_pkg;

  typedef enum logic [1:0] {
    MODE_TICK    = 2'd0,
    MODE_REQUEST = 2'd1,
    MODE_RELEASE = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PURGE,
    ST_SEARCH,
    ST_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic walk;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic go_purge;
    logic go_search;
    logic walk_done;
    logic last_slot;
  } dp_sts_t;

endpackage

// ===== rtl/lease_slot_arbiter_with_wait_queues_core.sv =====
// Channel     | dir | handshake            | payload
// in_*        | in  | in_valid / in_stall   | mode, slot, requester_id, time_value
// out_*       | out | out_valid / out_stall | granted, queued, dropped
//
// One transaction at a time. Release, ignored and direct-grant requests skip the walk.
// A queued request walks its slot's queue one entry per cycle.
// A tick updates all timers in parallel, then compacts each slot's queue in turn
// through the single queue RAM port pair.
// The result register lets the next transaction enter while a result is stalled.
// Synchronous active-low reset clears slots, counts and handshakes; no RAM sweep.
//
// Top level of the lease slot arbiter; depends on lsa_pkg, lsa_controller,
// lsa_datapath and lsa_ram.
module lease_slot_arbiter_with_wait_queues_core #(
  parameter int SLOT_COUNT  = 4,
  parameter int QUEUE_DEPTH = 32,
  parameter int ID_BITS     = 16,
  parameter int TIME_BITS   = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_mode,
  input  logic [1:0]           in_slot,
  input  logic [ID_BITS-1:0]   in_requester_id,
  input  logic [TIME_BITS-1:0] in_time_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_granted,
  output logic                 out_queued,
  output logic                 out_dropped
);

  // controller <-> datapath
  lsa_pkg::dp_cmd_t cmd;
  lsa_pkg::dp_sts_t sts;

  lsa_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // queues are circular per slot in one RAM; a tick purge compacts in place
  lsa_datapath #(
    .SLOT_COUNT  (SLOT_COUNT),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS),
    .TIME_BITS   (TIME_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_mode         (in_mode),
    .in_slot         (in_slot),
    .in_requester_id (in_requester_id),
    .in_time_value   (in_time_value),
    .out_granted     (out_granted),
    .out_queued      (out_queued),
    .out_dropped     (out_dropped)
  );

endmodule

// ===== rtl/lsa_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module lsa_ram #(
  parameter int WIDTH     = 17,
  parameter int DEPTH     = 128,
  parameter int ADDR_BITS = 7
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/lsa_datapath.sv =====
// Slot registers, queue RAM and walk engine of the lease slot arbiter.
// Depends on lsa_pkg and lsa_ram.
module lsa_datapath #(
  parameter int SLOT_COUNT  = 4,
  parameter int QUEUE_DEPTH = 32,
  parameter int ID_BITS     = 16,
  parameter int TIME_BITS   = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lsa_pkg::dp_cmd_t     cmd,
  output lsa_pkg::dp_sts_t     sts,
  input  logic [1:0]           in_mode,
  input  logic [1:0]           in_slot,
  input  logic [ID_BITS-1:0]   in_requester_id,
  input  logic [TIME_BITS-1:0] in_time_value,
  output logic                 out_granted,
  output logic                 out_queued,
  output logic                 out_dropped
);

  localparam int SLOT_BITS = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int PTR_BITS  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS  = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_BITS = SLOT_BITS + PTR_BITS;
  localparam int RAM_DEPTH = SLOT_COUNT << PTR_BITS;
  localparam int ENT_BITS  = ID_BITS + 1;

  // circular queue position head + k
  function automatic logic [PTR_BITS-1:0] qpos(input logic [PTR_BITS-1:0] h,
                                               input logic [CNT_BITS-1:0] k);
    logic [CNT_BITS:0] s;
    s = (CNT_BITS+1)'(h) + (CNT_BITS+1)'(k);
    if (s >= (CNT_BITS+1)'(QUEUE_DEPTH)) begin
      s = s - (CNT_BITS+1)'(QUEUE_DEPTH);
    end
    return PTR_BITS'(s);
  endfunction

  // latched transaction
  logic [1:0]           mode_r;
  logic                 slot_ok_r;
  logic [SLOT_BITS-1:0] slot_r;
  logic [ID_BITS-1:0]   id_r;
  logic [TIME_BITS-1:0] time_r;

  // per-slot state
  logic [ID_BITS-1:0]   owner_r [SLOT_COUNT];
  logic [ID_BITS-1:0]   owner_nxt [SLOT_COUNT];
  logic [TIME_BITS-1:0] lease_r [SLOT_COUNT];
  logic [TIME_BITS-1:0] lease_nxt [SLOT_COUNT];
  logic [TIME_BITS-1:0] rdl_r [SLOT_COUNT];
  logic [TIME_BITS-1:0] rdl_nxt [SLOT_COUNT];
  logic [PTR_BITS-1:0]  head_r [SLOT_COUNT];
  logic [PTR_BITS-1:0]  head_nxt [SLOT_COUNT];
  logic [CNT_BITS-1:0]  cnt_r [SLOT_COUNT];
  logic [CNT_BITS-1:0]  cnt_nxt [SLOT_COUNT];

  // walk engine
  logic [SLOT_BITS-1:0] cur_r, cur_nxt;
  logic [CNT_BITS-1:0]  issue_r, issue_nxt;
  logic [CNT_BITS-1:0]  wr_r, wr_nxt;
  logic [CNT_BITS-1:0]  pend_k_r, pend_k_nxt;
  logic                 pend_r, pend_nxt;
  logic                 found_r, found_nxt;
  logic                 popok_r, popok_nxt;
  logic                 g_r, g_nxt, q_r, q_nxt, d_r, d_nxt;

  logic                 is_tick;
  logic [CNT_BITS-1:0]  cur_cnt;
  logic [PTR_BITS-1:0]  cur_head;
  logic                 scan_end;
  logic                 walk_done;
  logic                 rd_en;
  logic                 grant_now;

  logic                 ram_we;
  logic [ADDR_BITS-1:0] ram_waddr, ram_raddr;
  logic [ENT_BITS-1:0]  ram_wdata, ram_rdata;
  logic [ID_BITS-1:0]   rd_id;
  logic                 rd_renewed;

  lsa_ram #(
    .WIDTH     (ENT_BITS),
    .DEPTH     (RAM_DEPTH),
    .ADDR_BITS (ADDR_BITS)
  ) u_queue_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_id      = ram_rdata[ENT_BITS-1:1];
  assign rd_renewed = ram_rdata[0];

  assign is_tick   = (mode_r == lsa_pkg::MODE_TICK);
  assign cur_cnt   = cnt_r[cur_r];
  assign cur_head  = head_r[cur_r];
  assign scan_end  = (issue_r == cur_cnt) && !pend_r;
  assign walk_done = is_tick ? scan_end : (found_r || scan_end);
  assign rd_en     = cmd.walk && (issue_r != cur_cnt) && (is_tick || !found_r);
  assign ram_raddr = {cur_r, qpos(cur_head, issue_r)};

  // owner already holding, or free slot with empty queue
  assign grant_now = ((owner_r[slot_r] != '0) && (owner_r[slot_r] == id_r) &&
                      (rdl_r[slot_r] == '0)) ||
                     ((owner_r[slot_r] == '0) && (cnt_r[slot_r] == '0));

  always_comb begin
    sts.go_purge  = is_tick;
    sts.go_search = (mode_r == lsa_pkg::MODE_REQUEST) && slot_ok_r && !grant_now;
    sts.walk_done = walk_done;
    sts.last_slot = (cur_r == SLOT_BITS'(SLOT_COUNT - 1));
  end

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      owner_nxt[i] = owner_r[i];
      lease_nxt[i] = lease_r[i];
      rdl_nxt[i]   = rdl_r[i];
      head_nxt[i]  = head_r[i];
      cnt_nxt[i]   = cnt_r[i];
    end
    cur_nxt    = cur_r;
    issue_nxt  = issue_r;
    wr_nxt     = wr_r;
    pend_nxt   = pend_r;
    pend_k_nxt = pend_k_r;
    found_nxt  = found_r;
    popok_nxt  = popok_r;
    g_nxt      = g_r;
    q_nxt      = q_r;
    d_nxt      = d_r;
    ram_we     = 1'b0;
    ram_waddr  = {cur_r, qpos(cur_head, wr_r)};
    ram_wdata  = {rd_id, 1'b0};

    if (cmd.exec) begin
      g_nxt     = 1'b0;
      q_nxt     = 1'b0;
      d_nxt     = 1'b0;
      issue_nxt = '0;
      wr_nxt    = '0;
      pend_nxt  = 1'b0;
      found_nxt = 1'b0;
      popok_nxt = (owner_r[slot_r] == '0);
      cur_nxt   = is_tick ? '0 : slot_r;
      if (is_tick) begin
        // all slot timers in parallel
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (owner_r[i] != '0) begin
            if (time_r > lease_r[i]) begin
              lease_nxt[i] = '0;
              owner_nxt[i] = '0;
              rdl_nxt[i]   = '0;
            end else begin
              lease_nxt[i] = lease_r[i] - time_r;
            end
            if (rdl_nxt[i] != '0) begin
              if (time_r > rdl_nxt[i]) begin
                owner_nxt[i] = '0;
                rdl_nxt[i]   = '0;
              end else begin
                rdl_nxt[i] = rdl_nxt[i] - time_r;
              end
            end
          end
        end
      end else if ((mode_r == lsa_pkg::MODE_REQUEST) && slot_ok_r && grant_now) begin
        g_nxt = 1'b1;
        if (owner_r[slot_r] == '0) begin
          owner_nxt[slot_r] = id_r;
          lease_nxt[slot_r] = time_r;
        end
      end else if ((mode_r == lsa_pkg::MODE_RELEASE) && slot_ok_r &&
                   (owner_r[slot_r] == id_r)) begin
        if (time_r == '0) begin
          owner_nxt[slot_r] = '0;
        end else begin
          rdl_nxt[slot_r] = time_r;
        end
      end
    end

    if (cmd.walk) begin
      if (rd_en) begin
        issue_nxt  = issue_r + 1'b1;
        pend_nxt   = 1'b1;
        pend_k_nxt = issue_r;
      end else begin
        pend_nxt = 1'b0;
      end

      if (is_tick) begin
        // compaction: survivors move down, renewed bit cleared
        if (pend_r && rd_renewed) begin
          ram_we    = 1'b1;
          ram_waddr = {cur_r, qpos(cur_head, wr_r)};
          ram_wdata = {rd_id, 1'b0};
          wr_nxt    = wr_r + 1'b1;
        end
        if (walk_done) begin
          cnt_nxt[cur_r] = wr_r;
          cur_nxt        = cur_r + 1'b1;
          issue_nxt      = '0;
          wr_nxt         = '0;
          pend_nxt       = 1'b0;
        end
      end else begin
        if (pend_r && !found_r && (rd_id == id_r)) begin
          found_nxt = 1'b1;
          if ((pend_k_r == '0) && popok_r) begin
            // requester at head of a free slot: pop and grant
            head_nxt[cur_r]  = qpos(cur_head, CNT_BITS'(1));
            cnt_nxt[cur_r]   = cur_cnt - 1'b1;
            owner_nxt[cur_r] = id_r;
            lease_nxt[cur_r] = time_r;
            g_nxt            = 1'b1;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = {cur_r, qpos(cur_head, pend_k_r)};
            ram_wdata = {id_r, 1'b1};
            q_nxt     = 1'b1;
          end
        end else if (scan_end && !found_r) begin
          if (cur_cnt < CNT_BITS'(QUEUE_DEPTH)) begin
            ram_we         = 1'b1;
            ram_waddr      = {cur_r, qpos(cur_head, cur_cnt)};
            ram_wdata      = {id_r, 1'b1};
            cnt_nxt[cur_r] = cur_cnt + 1'b1;
            q_nxt          = 1'b1;
          end else begin
            d_nxt = 1'b1;
          end
          found_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        owner_r[i] <= '0;
        lease_r[i] <= '0;
        rdl_r[i]   <= '0;
        head_r[i]  <= '0;
        cnt_r[i]   <= '0;
      end
      cur_r   <= '0;
      issue_r <= '0;
      wr_r    <= '0;
      pend_r  <= 1'b0;
      found_r <= 1'b0;
      popok_r <= 1'b0;
    end else begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        owner_r[i] <= owner_nxt[i];
        lease_r[i] <= lease_nxt[i];
        rdl_r[i]   <= rdl_nxt[i];
        head_r[i]  <= head_nxt[i];
        cnt_r[i]   <= cnt_nxt[i];
      end
      cur_r   <= cur_nxt;
      issue_r <= issue_nxt;
      wr_r    <= wr_nxt;
      pend_r  <= pend_nxt;
      found_r <= found_nxt;
      popok_r <= popok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_k_r <= pend_k_nxt;
    g_r      <= g_nxt;
    q_r      <= q_nxt;
    d_r      <= d_nxt;
    if (cmd.latch) begin
      mode_r    <= in_mode;
      slot_ok_r <= (32'(in_slot) < SLOT_COUNT);
      slot_r    <= SLOT_BITS'(in_slot);
      id_r      <= in_requester_id;
      time_r    <= in_time_value;
    end
    if (cmd.out_load) begin
      out_granted <= g_r;
      out_queued  <= q_r;
      out_dropped <= d_r;
    end
  end

endmodule

// ===== rtl/lsa_controller.sv =====
// Sequencing state machine and handshakes of the lease slot arbiter.
// Depends on lsa_pkg.
module lsa_controller (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  lsa_pkg::dp_sts_t sts,
  output lsa_pkg::dp_cmd_t cmd
);

  lsa_pkg::ctrl_state_t state_r, state_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != lsa_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lsa_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = lsa_pkg::ST_EXEC;
      end
      lsa_pkg::ST_EXEC: begin
        if (sts.go_purge)       state_nxt = lsa_pkg::ST_PURGE;
        else if (sts.go_search) state_nxt = lsa_pkg::ST_SEARCH;
        else                    state_nxt = lsa_pkg::ST_FINISH;
      end
      lsa_pkg::ST_PURGE: begin
        if (sts.walk_done && sts.last_slot) state_nxt = lsa_pkg::ST_FINISH;
      end
      lsa_pkg::ST_SEARCH: begin
        if (sts.walk_done) state_nxt = lsa_pkg::ST_FINISH;
      end
      lsa_pkg::ST_FINISH: begin
        if (out_free) state_nxt = lsa_pkg::ST_IDLE;
      end
      default: state_nxt = lsa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      lsa_pkg::ST_IDLE:   cmd.latch    = in_valid;
      lsa_pkg::ST_EXEC:   cmd.exec     = 1'b1;
      lsa_pkg::ST_PURGE:  cmd.walk     = 1'b1;
      lsa_pkg::ST_SEARCH: cmd.walk     = 1'b1;
      lsa_pkg::ST_FINISH: cmd.out_load = out_free;
      default:            cmd          = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load)       out_valid_nxt = 1'b1;
    else if (!out_stall)    out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lsa_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/lsa_checker.sv =====
// Port-level checks for the lease slot arbiter, bound to the top level.
// Depends on lease_slot_arbiter_with_wait_queues_core_defines.svh.
`include "lease_slot_arbiter_with_wait_queues_core_defines.svh"

module lsa_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_granted,
  input logic out_queued,
  input logic out_dropped
);

  `LSA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
  `LSA_ASSERT_NOW(a_one_flag, out_valid, ((out_granted & out_queued) | (out_granted & out_dropped) | (out_queued & out_dropped)) == 1'b0, "more than one result flag")
  `LSA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "second transaction taken while busy")

endmodule

bind lease_slot_arbiter_with_wait_queues_core lsa_checker u_lsa_checker (.*);
